[design/pcmf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmf_pkg: shared types and constants for the PCM float sample converter
// Register addresses, format codes and the configuration struct.
// ----------------------------------------------------------------------------
package pcmf_pkg;

	typedef enum logic [1:0] {
		FMT_U8  = 2'd0,
		FMT_S16 = 2'd1,
		FMT_S32 = 2'd2,
		FMT_RSV = 2'd3
	} fmt_t;

	typedef enum logic [0:0] {
		DIR_I2F = 1'b0,
		DIR_F2I = 1'b1
	} dir_t;

	localparam logic [0:0] ADDR_DIRECTION  = 1'b0;
	localparam logic [0:0] ADDR_INT_FORMAT = 1'b1;

	typedef struct packed {
		dir_t direction;
		fmt_t int_format;
	} cfg_t;

endpackage

[design/pcmf_i2f.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmf_i2f: integer PCM to float32
// Scales sample by 2^-(N-1), rounds the 32-bit case to nearest even.
// ----------------------------------------------------------------------------
module pcmf_i2f
	import pcmf_pkg::*;
(
	input  logic [31:0] x,
	input  fmt_t        fmt,
	output logic [31:0] y
);
	logic        sign;
	logic [31:0] mag;
	logic [7:0]  k;
	logic [4:0]  p;
	logic [31:0] norm;
	logic [24:0] q;
	logic        rnd;
	logic        sticky;
	logic [7:0]  e;

	always_comb begin
		unique case (fmt)
			FMT_U8: begin
				sign = ~x[7];
				mag  = x[7] ? {24'd0, 1'b0, x[6:0]} : (32'd128 - {24'd0, x[7:0]});
				k    = 8'd7;
			end
			FMT_S16: begin
				sign = x[15];
				mag  = x[15] ? (32'h10000 - {16'd0, x[15:0]}) : {16'd0, x[15:0]};
				k    = 8'd15;
			end
			default: begin
				sign = x[31];
				mag  = x[31] ? (32'd0 - x) : x;
				k    = 8'd31;
			end
		endcase
	end

	always_comb begin
		p = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (mag[i]) p = 5'(i);
		end
	end

	always_comb begin
		norm   = mag << (5'd31 - p);
		sticky = |norm[6:0];
		rnd    = norm[7] & (sticky | norm[8]);
		q      = {1'b0, norm[31:8]} + {24'd0, rnd};
		e      = 8'd127 + {3'd0, p} - k + {7'd0, q[24]};
		if (mag == 32'd0) y = 32'd0;
		else if (q[24]) y = {sign, e, 23'd0};
		else y = {sign, e, q[22:0]};
	end
endmodule

[design/pcmf_f2i.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmf_f2i: float32 to integer PCM
// Scales by 2^(N-1), truncates toward zero and saturates; NaN gives silence.
// ----------------------------------------------------------------------------
module pcmf_f2i
	import pcmf_pkg::*;
(
	input  logic [31:0] x,
	input  fmt_t        fmt,
	output logic [31:0] y
);
	logic        sign;
	logic [7:0]  e;
	logic [22:0] m;
	logic [23:0] mm;
	logic [4:0]  s;
	logic signed [9:0] ex;
	logic        big;
	logic [32:0] mag;
	logic [32:0] maxpos;
	logic [32:0] maxneg;
	logic [31:0] mask;
	logic [31:0] r;

	always_comb begin
		sign = x[31];
		e    = x[30:23];
		m    = x[22:0];
		unique case (fmt)
			FMT_U8:  s = 5'd7;
			FMT_S16: s = 5'd15;
			default: s = 5'd31;
		endcase
		mm     = (e == 8'd0) ? {1'b0, m} : {1'b1, m};
		ex     = ((e == 8'd0) ? -10'sd149 : ($signed({2'b0, e}) - 10'sd150))
			+ $signed({5'd0, s});
		maxneg = 33'd1 << s;
		maxpos = maxneg - 33'd1;
		mask   = 32'(({1'b0, maxneg} << 1) - 34'd1);
		big    = (e == 8'hFF) || (ex >= 10'sd9);
		mag    = 33'd0;
		if (big) mag = {33{1'b1}};
		else if (ex >= 10'sd0) mag = {9'd0, mm} << ex[3:0];
		else if (ex > -10'sd32) mag = {9'd0, mm} >> (-ex);
		if (e == 8'hFF && m != 23'd0) r = 32'd0;
		else if (sign) r = (mag >= maxneg) ? 32'(maxneg) & mask : 32'(33'd0 - mag) & mask;
		else r = (mag > maxpos) ? 32'(maxpos) : 32'(mag);
		y = (fmt == FMT_U8) ? {24'd0, r[7:0] + 8'd128} : r;
	end
endmodule

[design/pcm_float_sample_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_float_sample_converter: PCM integer <-> float32 sample converter
// Input register, one pass of conversion logic, skid-free output register.
//
// channel | dir | tdata                       | tlast
// s_axis  | in  | sample_in[31:0]             | last_in
// m_axis  | out | sample_out[31:0]            | last_out
// apb     | in  | reg 0 direction, reg 1 int_format at 4*i
//
// One sample per cycle unless m_axis stalls; input then result register.
// Reset clears valid flags and sets direction 0, int_format 1.
// A stalled result holds; the input register advances whenever its content moves.
// ----------------------------------------------------------------------------
module pcm_float_sample_converter
	import pcmf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // sample_in
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // sample_out
	output logic        m_axis_tlast
);
	cfg_t        cfg_q;
	logic        vld_s1;
	logic [31:0] data_s1;
	logic        last_s1;
	logic        vld_s2;
	logic [31:0] data_s2;
	logic        last_s2;
	logic [31:0] i2f_y;
	logic [31:0] f2i_y;
	logic        adv2;
	logic        adv1;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{direction: DIR_I2F, int_format: FMT_S16};
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				ADDR_DIRECTION:  cfg_q.direction  <= dir_t'(pwdata[0]);
				ADDR_INT_FORMAT: cfg_q.int_format <= fmt_t'(pwdata[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			ADDR_DIRECTION:  prdata = {31'd0, cfg_q.direction};
			default:         prdata = {30'd0, cfg_q.int_format};
		endcase
	end

	assign adv2 = !vld_s2 || m_axis_tready;
	assign adv1 = !vld_s1 || adv2;
	assign s_axis_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= s_axis_tvalid;
			if (adv2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (adv2) begin
			data_s2 <= (cfg_q.direction == DIR_F2I) ? f2i_y : i2f_y;
			last_s2 <= last_s1;
		end
	end

	pcmf_i2f u_i2f (.x(data_s1), .fmt(cfg_q.int_format), .y(i2f_y));
	pcmf_f2i u_f2i (.x(data_s1), .fmt(cfg_q.int_format), .y(f2i_y));

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = data_s2;
	assign m_axis_tlast  = last_s2;

`ifndef NO_ASSERTIONS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output");
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv2 |=> vld_s2)
		else $error("item lost between stages");
`endif
endmodule
